// File: src/voxel_grid_box_sphere_fill_assert.svh
// ----------------------------------------------------------------------------
// voxel grid fill: assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_BOX_SPHERE_FILL_ASSERT_SVH
`define VOXEL_GRID_BOX_SPHERE_FILL_ASSERT_SVH

// condition holds at every edge
`define VGBSF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VGBSF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: src/vgbsf_pkg.sv
// ----------------------------------------------------------------------------
// voxel grid fill: shared package
// command and register codes, job and status types, sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package vgbsf_pkg;

	localparam int DEF_X_SIZE = 32;
	localparam int DEF_Y_SIZE = 32;
	localparam int DEF_Z_SIZE = 32;

	localparam logic [4:0] SMALL_RADIUS = 5'd3;

	localparam logic [2:0] CMD_PUT_VOXEL  = 3'd0;
	localparam logic [2:0] CMD_CUT_VOXEL  = 3'd1;
	localparam logic [2:0] CMD_PUT_BOX    = 3'd2;
	localparam logic [2:0] CMD_CUT_BOX    = 3'd3;
	localparam logic [2:0] CMD_PUT_SPHERE = 3'd4;
	localparam logic [2:0] CMD_CUT_SPHERE = 3'd5;
	localparam logic [2:0] CMD_READ_VOXEL = 3'd6;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_DRAW_RED   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DRAW_GREEN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DRAW_BLUE  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DRAW_ALPHA = 2'd3;

	localparam logic [7:0] RESET_RED   = 8'd0;
	localparam logic [7:0] RESET_GREEN = 8'd0;
	localparam logic [7:0] RESET_BLUE  = 8'd0;
	localparam logic [7:0] RESET_ALPHA = 8'd255;

	localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [4:0] coord_t;
	typedef logic [5:0] span_t;

	typedef enum logic [1:0] {
		SHAPE_NONE,
		SHAPE_VOXEL,
		SHAPE_BOX,
		SHAPE_SPHERE
	} shape_t;

	typedef struct packed {
		logic  empty;
		span_t lo;
		span_t hi;
	} range_t;

	typedef struct packed {
		logic   fill;
		logic   sphere;
		logic   empty;
		logic   ingrid;
		span_t  xlo;
		span_t  xhi;
		span_t  ylo;
		span_t  yhi;
		span_t  zlo;
		span_t  zhi;
		coord_t xf;
		coord_t yf;
		coord_t zf;
		coord_t radius;
	} job_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_READ
	} state_t;

endpackage

`default_nettype wire

// File: src/vgbsf_cmd_if.sv
// ----------------------------------------------------------------------------
// voxel grid fill: command channel
// valid/ready channel carrying one command beat
// ----------------------------------------------------------------------------
`default_nettype none

interface vgbsf_cmd_if import vgbsf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] command;
	coord_t     x_first;
	coord_t     x_last;
	coord_t     y_first;
	coord_t     y_last;
	coord_t     z_first;
	coord_t     z_last;
	coord_t     radius;

	modport source (
		output valid, command, x_first, x_last, y_first, y_last, z_first, z_last, radius,
		input  ready
	);

	modport sink (
		input  valid, command, x_first, x_last, y_first, y_last, z_first, z_last, radius,
		output ready
	);
endinterface

`default_nettype wire

// File: src/vgbsf_res_if.sv
// ----------------------------------------------------------------------------
// voxel grid fill: result channel
// valid/ready channel carrying one result beat
// ----------------------------------------------------------------------------
`default_nettype none

interface vgbsf_res_if;
	logic        valid;
	logic        ready;
	logic        voxel_shown;
	logic [7:0]  voxel_red;
	logic [7:0]  voxel_green;
	logic [7:0]  voxel_blue;
	logic [7:0]  voxel_alpha;
	logic [15:0] shown_total;

	modport source (
		output valid, voxel_shown, voxel_red, voxel_green, voxel_blue, voxel_alpha,
		output shown_total,
		input  ready
	);

	modport sink (
		input  valid, voxel_shown, voxel_red, voxel_green, voxel_blue, voxel_alpha,
		input  shown_total,
		output ready
	);
endinterface

`default_nettype wire

// File: src/vgbsf_front.sv
// ----------------------------------------------------------------------------
// voxel grid fill: front end
// takes command beats and turns them into clipped sweep jobs for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module vgbsf_front import vgbsf_pkg::*; #(
	parameter int X_SIZE = DEF_X_SIZE,
	parameter int Y_SIZE = DEF_Y_SIZE,
	parameter int Z_SIZE = DEF_Z_SIZE
) (
	vgbsf_cmd_if.sink  cmd,
	input  back_stat_t bstat,
	input  q_stat_t    qstat,
	output logic       push,
	output job_t       push_data
);

	localparam logic [8:0] X_LIMIT = 9'(X_SIZE - 1);
	localparam logic [8:0] Y_LIMIT = 9'(Y_SIZE - 1);
	localparam logic [8:0] Z_LIMIT = 9'(Z_SIZE - 1);

	function automatic range_t axis_range(input shape_t shape, input coord_t first,
			input coord_t last, input coord_t radius, input logic [8:0] limit);
		logic [8:0] f9;
		logic [8:0] l9;
		logic [8:0] lo9;
		logic [8:0] sum9;
		range_t     r;
		f9   = 9'(first);
		l9   = 9'(last);
		sum9 = f9 + 9'(radius);
		lo9  = (first >= radius) ? 9'(first - radius) : 9'd0;
		r    = '0;
		unique case (shape)
			SHAPE_VOXEL: begin
				r.empty = f9 > limit;
				r.lo    = span_t'(f9);
				r.hi    = span_t'(f9);
			end
			SHAPE_BOX: begin
				r.empty = (l9 < f9) || (f9 > limit);
				r.lo    = span_t'(f9);
				r.hi    = span_t'((l9 > limit) ? limit : l9);
			end
			SHAPE_SPHERE: begin
				r.empty = lo9 > limit;
				r.lo    = span_t'(lo9);
				r.hi    = span_t'((sum9 > limit) ? limit : sum9);
			end
			default: begin
				r.empty = 1'b1;
			end
		endcase
		return r;
	endfunction

	shape_t shape;
	logic   fill;
	range_t rx;
	range_t ry;
	range_t rz;

	always_comb begin
		unique case (cmd.command) inside
			CMD_PUT_VOXEL, CMD_CUT_VOXEL:   shape = SHAPE_VOXEL;
			CMD_PUT_BOX, CMD_CUT_BOX:       shape = SHAPE_BOX;
			CMD_PUT_SPHERE, CMD_CUT_SPHERE: shape = SHAPE_SPHERE;
			default:                        shape = SHAPE_NONE;
		endcase
		unique case (cmd.command) inside
			CMD_PUT_VOXEL, CMD_PUT_BOX, CMD_PUT_SPHERE: fill = 1'b1;
			default:                                    fill = 1'b0;
		endcase
	end

	assign rx = axis_range(shape, cmd.x_first, cmd.x_last, cmd.radius, X_LIMIT);
	assign ry = axis_range(shape, cmd.y_first, cmd.y_last, cmd.radius, Y_LIMIT);
	assign rz = axis_range(shape, cmd.z_first, cmd.z_last, cmd.radius, Z_LIMIT);

	always_comb begin
		push_data.fill   = fill;
		push_data.sphere = shape == SHAPE_SPHERE;
		push_data.empty  = rx.empty || ry.empty || rz.empty;
		push_data.ingrid = (9'(cmd.x_first) <= X_LIMIT) && (9'(cmd.y_first) <= Y_LIMIT)
			&& (9'(cmd.z_first) <= Z_LIMIT);
		push_data.xlo    = rx.lo;
		push_data.xhi    = rx.hi;
		push_data.ylo    = ry.lo;
		push_data.yhi    = ry.hi;
		push_data.zlo    = rz.lo;
		push_data.zhi    = rz.hi;
		push_data.xf     = cmd.x_first;
		push_data.yf     = cmd.y_first;
		push_data.zf     = cmd.z_first;
		push_data.radius = cmd.radius;
	end

	assign cmd.ready = !qstat.full && !bstat.clearing;
	assign push      = cmd.valid && cmd.ready;

endmodule

`default_nettype wire

// File: src/vgbsf_fifo.sv
// ----------------------------------------------------------------------------
// voxel grid fill: job queue
// short first-in first-out store between the front end and the sweep engine
// ----------------------------------------------------------------------------
`default_nettype none

module vgbsf_fifo import vgbsf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_data,
	input  logic    pop,
	output job_t    pop_data,
	output q_stat_t stat
);

	job_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data      = ent_q[rd_ptr_q];
	assign stat.full     = fill_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign stat.nonempty = fill_q != '0;

endmodule

`default_nettype wire

// File: src/vgbsf_back.sv
// ----------------------------------------------------------------------------
// voxel grid fill: sweep engine
// walks each job one voxel a cycle over the mark and colour stores
// ----------------------------------------------------------------------------
`default_nettype none

module vgbsf_back import vgbsf_pkg::*; #(
	parameter int X_SIZE = DEF_X_SIZE,
	parameter int Y_SIZE = DEF_Y_SIZE,
	parameter int Z_SIZE = DEF_Z_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	input  logic [31:0] draw_colour,
	output back_stat_t  stat,
	vgbsf_res_if.source res
);

	localparam int XW    = (X_SIZE > 1) ? $clog2(X_SIZE) : 1;
	localparam int YW    = (Y_SIZE > 1) ? $clog2(Y_SIZE) : 1;
	localparam int ZW    = (Z_SIZE > 1) ? $clog2(Z_SIZE) : 1;
	localparam int AW    = XW + YW + ZW;
	localparam int DEPTH = 1 << AW;
	localparam int CELLS = X_SIZE * Y_SIZE * Z_SIZE;
	localparam int CNT_W = ($clog2(CELLS + 1) > 16) ? $clog2(CELLS + 1) : 16;

	typedef struct packed {
		logic          valid;
		logic          rd;
		logic          wr;
		logic          fill;
		logic          ingrid;
		logic [AW-1:0] addr;
	} op_t;

	function automatic logic [AW-1:0] addr_of(input span_t x, input span_t y, input span_t z);
		return {XW'(x), YW'(y), ZW'(z)};
	endfunction

	state_t           state_q;
	state_t           state_d;
	job_t             job_q;
	span_t            cx_q;
	span_t            cy_q;
	span_t            cz_q;
	span_t            cx_d;
	span_t            cy_d;
	span_t            cz_d;
	logic [AW-1:0]    clr_addr_q;
	op_t              issue;
	op_t              op_s2;
	logic             byp_sh_s2;
	logic             byp_val_s2;
	logic             byp_col_s2;
	logic             shown_mem [DEPTH];
	logic [31:0]      colour_mem [DEPTH];
	logic             sh_rd_s2;
	logic [31:0]      col_rd_s2;
	logic             sh_we;
	logic [AW-1:0]    sh_waddr;
	logic             sh_wdata;
	logic             col_we;
	logic             old_sh;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic             res_shown_q;
	logic [31:0]      res_col_q;
	logic [15:0]      res_total_q;
	span_t            adx;
	span_t            ady;
	span_t            adz;
	logic [11:0]      sqx;
	logic [11:0]      sqy;
	logic [11:0]      sqz;
	logic [13:0]      d2;
	logic [9:0]       r2;
	logic             in_ball;

	// sphere membership of the current voxel
	always_comb begin
		adx     = (cx_q >= span_t'(job_q.xf)) ? cx_q - span_t'(job_q.xf) : span_t'(job_q.xf) - cx_q;
		ady     = (cy_q >= span_t'(job_q.yf)) ? cy_q - span_t'(job_q.yf) : span_t'(job_q.yf) - cy_q;
		adz     = (cz_q >= span_t'(job_q.zf)) ? cz_q - span_t'(job_q.zf) : span_t'(job_q.zf) - cz_q;
		sqx     = 12'(adx) * 12'(adx);
		sqy     = 12'(ady) * 12'(ady);
		sqz     = 12'(adz) * 12'(adz);
		d2      = 14'(sqx) + 14'(sqy) + 14'(sqz);
		r2      = 10'(job_q.radius) * 10'(job_q.radius);
		in_ball = (d2 < 14'(r2)) || ((job_q.radius <= SMALL_RADIUS) && (d2 == 14'(r2)));
	end

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		issue   = '0;
		cx_d    = cx_q;
		cy_d    = cy_q;
		cz_d    = cz_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					cx_d    = job.xlo;
					cy_d    = job.ylo;
					cz_d    = job.zlo;
					state_d = job.empty ? ST_READ : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				issue.valid = 1'b1;
				issue.wr    = !job_q.sphere || in_ball;
				issue.fill  = job_q.fill;
				issue.addr  = addr_of(cx_q, cy_q, cz_q);
				if (cz_q == job_q.zhi) begin
					cz_d = job_q.zlo;
					if (cy_q == job_q.yhi) begin
						cy_d = job_q.ylo;
						if (cx_q == job_q.xhi) begin
							state_d = ST_READ;
						end else begin
							cx_d = cx_q + 6'd1;
						end
					end else begin
						cy_d = cy_q + 6'd1;
					end
				end else begin
					cz_d = cz_q + 6'd1;
				end
			end
			ST_READ: begin
				if (!out_valid_q && !(op_s2.valid && op_s2.rd)) begin
					issue.valid  = 1'b1;
					issue.rd     = 1'b1;
					issue.ingrid = job_q.ingrid;
					issue.addr   = addr_of(span_t'(job_q.xf), span_t'(job_q.yf), span_t'(job_q.zf));
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		cx_q       <= cx_d;
		cy_q       <= cy_d;
		cz_q       <= cz_d;
		byp_sh_s2  <= op_s2.valid && op_s2.wr && (op_s2.addr == issue.addr);
		byp_val_s2 <= op_s2.fill;
		byp_col_s2 <= op_s2.valid && op_s2.wr && op_s2.fill && (op_s2.addr == issue.addr);
	end

	// stores
	assign sh_we    = (state_q == ST_CLEAR) || (op_s2.valid && op_s2.wr);
	assign sh_waddr = (state_q == ST_CLEAR) ? clr_addr_q : op_s2.addr;
	assign sh_wdata = (state_q != ST_CLEAR) && op_s2.fill;
	assign col_we   = op_s2.valid && op_s2.wr && op_s2.fill;

	always_ff @(posedge clk) begin
		if (sh_we) begin
			shown_mem[sh_waddr] <= sh_wdata;
		end
		sh_rd_s2 <= shown_mem[issue.addr];
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			colour_mem[op_s2.addr] <= draw_colour;
		end
		col_rd_s2 <= colour_mem[issue.addr];
	end

	assign old_sh = byp_sh_s2 ? byp_val_s2 : sh_rd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			op_s2 <= issue;
			if (op_s2.valid && op_s2.wr) begin
				if (op_s2.fill && !old_sh) begin
					count_q <= count_q + CNT_W'(1);
				end else if (!op_s2.fill && old_sh) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (op_s2.valid && op_s2.rd) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_s2.valid && op_s2.rd) begin
			res_shown_q <= op_s2.ingrid && old_sh;
			res_col_q   <= !op_s2.ingrid ? 32'd0 : (byp_col_s2 ? draw_colour : col_rd_s2);
			res_total_q <= (count_q > CNT_W'(TOTAL_MAX)) ? TOTAL_MAX : count_q[15:0];
		end
	end

	assign res.valid       = out_valid_q;
	assign res.voxel_shown = res_shown_q;
	assign res.voxel_red   = res_col_q[31:24];
	assign res.voxel_green = res_col_q[23:16];
	assign res.voxel_blue  = res_col_q[15:8];
	assign res.voxel_alpha = res_col_q[7:0];
	assign res.shown_total = res_total_q;

	assign stat.clearing = state_q == ST_CLEAR;

endmodule

`default_nettype wire

// File: src/voxel_grid_box_sphere_fill.sv
// ----------------------------------------------------------------------------
// voxel grid box and sphere fill
// Keeps a 3D grid of voxels, each with a shown mark and an RGBA colour.
// cmd: one beat per command (put/cut voxel, box or sphere, read voxel).
// res: one beat per command with the voxel at the first corner or centre
//   after the command and the running count of shown voxels.
// cfg: write enable, index and data set the drawing colour channels.
// Each command sweeps the V voxels of its clipped bounding box (1 for a
//   single voxel, 0 for a read, up to 32768 at the default size), and its
//   final read waits until the result register has drained; the mark store
//   takes one read-modify-write a cycle.
// A two-deep job queue takes further commands.
// After reset the mark store is cleared one entry a cycle, all
//   2^(clog2 X + clog2 Y + clog2 Z) entries (32768 by default), with cmd
//   ready held low.
// A stalled receiver holds the result beat; the engine then waits before
//   finishing the next command and cmd ready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_grid_box_sphere_fill_assert.svh"

module voxel_grid_box_sphere_fill import vgbsf_pkg::*; #(
	parameter int X_SIZE = DEF_X_SIZE,
	parameter int Y_SIZE = DEF_Y_SIZE,
	parameter int Z_SIZE = DEF_Z_SIZE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	vgbsf_cmd_if.sink              cmd,
	vgbsf_res_if.source            res
);

	localparam int          CELLS     = X_SIZE * Y_SIZE * Z_SIZE;
	localparam logic [15:0] TOTAL_CAP = (CELLS > 65535) ? TOTAL_MAX : 16'(CELLS);

	logic [7:0] draw_red_q;
	logic [7:0] draw_green_q;
	logic [7:0] draw_blue_q;
	logic [7:0] draw_alpha_q;
	logic       q_push;
	job_t       q_push_data;
	logic       q_pop;
	job_t       q_pop_data;
	q_stat_t    qstat;
	back_stat_t bstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_red_q   <= RESET_RED;
			draw_green_q <= RESET_GREEN;
			draw_blue_q  <= RESET_BLUE;
			draw_alpha_q <= RESET_ALPHA;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DRAW_RED:   draw_red_q   <= cfg_data;
				REG_DRAW_GREEN: draw_green_q <= cfg_data;
				REG_DRAW_BLUE:  draw_blue_q  <= cfg_data;
				REG_DRAW_ALPHA: draw_alpha_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vgbsf_front #(
		.X_SIZE (X_SIZE),
		.Y_SIZE (Y_SIZE),
		.Z_SIZE (Z_SIZE)
	) u_front (
		.cmd       (cmd),
		.bstat     (bstat),
		.qstat     (qstat),
		.push      (q_push),
		.push_data (q_push_data)
	);

	vgbsf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.stat      (qstat)
	);

	vgbsf_back #(
		.X_SIZE (X_SIZE),
		.Y_SIZE (Y_SIZE),
		.Z_SIZE (Z_SIZE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (qstat.nonempty),
		.job         (q_pop_data),
		.job_pop     (q_pop),
		.draw_colour ({draw_red_q, draw_green_q, draw_blue_q, draw_alpha_q}),
		.stat        (bstat),
		.res         (res)
	);

	`VGBSF_ASSERT_IMP(a_no_cmd_in_clear, cmd.valid && cmd.ready, !bstat.clearing, "command beat taken during clearing pass")
	`VGBSF_ASSERT_IMP(a_no_push_full, q_push, !qstat.full, "job queue written while full")
	`VGBSF_ASSERT_IMP(a_no_pop_empty, q_pop, qstat.nonempty, "job queue read while empty")
	`VGBSF_ASSERT_IMP(a_total_cap, res.valid, res.shown_total <= TOTAL_CAP, "shown total beyond grid size")

endmodule

`default_nettype wire

// File: bench/voxel_grid_box_sphere_fill_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel grid box and sphere fill: testbench
// Drives put, cut and read commands for single voxels, boxes and spheres
// into the block. Sender bursts and receiver stalls are random, and one long
// receiver hold-off backs the block up. A local copy of the grid, with its
// marks, colours and shown count, predicts every result beat. Each beat is
// checked field by field, and the drawing colour changes between phases.
// ----------------------------------------------------------------------------

module voxel_grid_box_sphere_fill_test import vgbsf_pkg::*; ();

	localparam int GX = DEF_X_SIZE;
	localparam int GY = DEF_Y_SIZE;
	localparam int GZ = DEF_Z_SIZE;
	localparam int VOXELS = GX * GY * GZ;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int HOLD_AT = 35;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 20;

	typedef struct {
		logic [2:0] command;
		coord_t     x_first;
		coord_t     x_last;
		coord_t     y_first;
		coord_t     y_last;
		coord_t     z_first;
		coord_t     z_last;
		coord_t     radius;
	} draw_cmd_t;

	typedef struct {
		logic        shown;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] total;
	} voxel_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]             cfg_data;

	vgbsf_cmd_if cmd ();
	vgbsf_res_if res ();

	voxel_grid_box_sphere_fill dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res       (res)
	);

	// local copy of the grid
	bit          shown_map [VOXELS];
	logic [31:0] colour_map [VOXELS];
	int unsigned shown_count = 0;
	logic [31:0] draw_colour = {RESET_RED, RESET_GREEN, RESET_BLUE, RESET_ALPHA};

	draw_cmd_t     pending_cmds [$];
	draw_cmd_t     on_bus;
	voxel_report_t expected_reports [$];
	int            queued_count = 0;
	int            accepted_count = 0;
	int            results_seen;
	int            failures = 0;
	int            burst_left;
	int            gap_left;
	int            hold_left;
	bit            hold_done;
	logic [9:0]    stall_tick;
	longint        cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void paint_voxel(bit fill, int x, int y, int z);
		int idx;
		if (x < 0 || x >= GX || y < 0 || y >= GY || z < 0 || z >= GZ)
			return;
		idx = (x * GY + y) * GZ + z;
		if (fill) begin
			if (!shown_map[idx])
				shown_count++;
			shown_map[idx] = 1'b1;
			colour_map[idx] = draw_colour;
		end else begin
			if (shown_map[idx])
				shown_count--;
			shown_map[idx] = 1'b0;
		end
	endfunction

	function automatic voxel_report_t apply_command(draw_cmd_t c);
		int xf, xl, yf, yl, zf, zl, r, r2, d2, idx;
		bit fill;
		voxel_report_t rep;
		xf = int'(c.x_first);
		xl = int'(c.x_last);
		yf = int'(c.y_first);
		yl = int'(c.y_last);
		zf = int'(c.z_first);
		zl = int'(c.z_last);
		r = int'(c.radius);
		r2 = r * r;
		fill = (c.command == CMD_PUT_VOXEL || c.command == CMD_PUT_BOX ||
			c.command == CMD_PUT_SPHERE);
		case (c.command)
			CMD_PUT_VOXEL, CMD_CUT_VOXEL: begin
				paint_voxel(fill, xf, yf, zf);
			end
			CMD_PUT_BOX, CMD_CUT_BOX: begin
				if (xl >= xf && yl >= yf && zl >= zf)
					for (int x = xf; x <= xl; x++)
						for (int y = yf; y <= yl; y++)
							for (int z = zf; z <= zl; z++)
								paint_voxel(fill, x, y, z);
			end
			CMD_PUT_SPHERE, CMD_CUT_SPHERE: begin
				for (int dx = -r; dx <= r; dx++)
					for (int dy = -r; dy <= r; dy++)
						for (int dz = -r; dz <= r; dz++) begin
							d2 = dx * dx + dy * dy + dz * dz;
							if (d2 < r2 || (r <= int'(SMALL_RADIUS) && d2 == r2))
								paint_voxel(fill, xf + dx, yf + dy, zf + dz);
						end
			end
			default: ;
		endcase
		idx = (xf * GY + yf) * GZ + zf;
		rep.shown = shown_map[idx];
		{rep.red, rep.green, rep.blue, rep.alpha} = colour_map[idx];
		rep.total = (shown_count > TOTAL_MAX) ? TOTAL_MAX : shown_count[15:0];
		return rep;
	endfunction

	function automatic draw_cmd_t mk(logic [2:0] op, coord_t xf, coord_t xl, coord_t yf,
			coord_t yl, coord_t zf, coord_t zl, coord_t r);
		draw_cmd_t c;
		c.command = op;
		c.x_first = xf;
		c.x_last = xl;
		c.y_first = yf;
		c.y_last = yl;
		c.z_first = zf;
		c.z_last = zl;
		c.radius = r;
		return c;
	endfunction

	function automatic coord_t box_end(coord_t first, bit big);
		int e;
		e = int'(first) + int'(big ? $urandom_range(0, 31) : $urandom_range(0, 3));
		return (e > 31) ? coord_t'(31) : coord_t'(e);
	endfunction

	// mostly small shapes, now and then a large one
	function automatic draw_cmd_t random_cmd();
		draw_cmd_t c;
		bit big;
		c.command = ($urandom_range(0, 15) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 6));
		big = ($urandom_range(0, 19) == 0);
		c.x_first = coord_t'($urandom_range(0, 31));
		c.y_first = coord_t'($urandom_range(0, 31));
		c.z_first = coord_t'($urandom_range(0, 31));
		c.x_last = coord_t'($urandom_range(0, 31));
		c.y_last = coord_t'($urandom_range(0, 31));
		c.z_last = coord_t'($urandom_range(0, 31));
		c.radius = coord_t'($urandom_range(0, 31));
		if (c.command == CMD_PUT_BOX || c.command == CMD_CUT_BOX) begin
			c.x_last = box_end(c.x_first, big);
			c.y_last = box_end(c.y_first, big);
			c.z_last = box_end(c.z_first, big);
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						c.x_first = coord_t'($urandom_range(1, 31));
						c.x_last = c.x_first - coord_t'(1);
					end
					1: begin
						c.y_first = coord_t'($urandom_range(1, 31));
						c.y_last = c.y_first - coord_t'(1);
					end
					default: begin
						c.z_first = coord_t'($urandom_range(1, 31));
						c.z_last = c.z_first - coord_t'(1);
					end
				endcase
			end
		end
		if (c.command == CMD_PUT_SPHERE || c.command == CMD_CUT_SPHERE)
			c.radius = coord_t'(big ? $urandom_range(8, 31) : $urandom_range(0, 4));
		return c;
	endfunction

	function automatic void queue_cmd(draw_cmd_t c);
		pending_cmds.push_back(c);
		queued_count++;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			failures++;
		end
	endfunction

	task automatic set_draw(input logic [7:0] r, g, b, a);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DRAW_RED;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= REG_DRAW_GREEN;
		cfg_data <= g;
		@(posedge clk);
		cfg_index <= REG_DRAW_BLUE;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= REG_DRAW_ALPHA;
		cfg_data <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		draw_colour = {r, g, b, a};
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (accepted_count != queued_count || expected_reports.size() != 0);
	endtask

	// command driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.command <= CMD_READ_VOXEL;
			cmd.x_first <= '0;
			cmd.x_last <= '0;
			cmd.y_first <= '0;
			cmd.y_last <= '0;
			cmd.z_first <= '0;
			cmd.z_last <= '0;
			cmd.radius <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				expected_reports.push_back(apply_command(on_bus));
				accepted_count++;
			end
			if (!cmd.valid || cmd.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					on_bus = pending_cmds.pop_front();
					cmd.command <= on_bus.command;
					cmd.x_first <= on_bus.x_first;
					cmd.x_last <= on_bus.x_last;
					cmd.y_first <= on_bus.y_first;
					cmd.y_last <= on_bus.y_last;
					cmd.z_first <= on_bus.z_first;
					cmd.z_last <= on_bus.z_last;
					cmd.radius <= on_bus.radius;
					cmd.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin : watch_results
		voxel_report_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_tick <= '0;
			results_seen <= 0;
		end else begin
			if (res.valid && res.ready) begin
				results_seen <= results_seen + 1;
				if (expected_reports.size() == 0) begin
					$display("%0t: result beat expected none got total %0h", $time,
						res.shown_total);
					failures++;
				end else begin
					want = expected_reports.pop_front();
					check_field("voxel_shown", want.shown, res.voxel_shown);
					check_field("voxel_red", want.red, res.voxel_red);
					check_field("voxel_green", want.green, res.voxel_green);
					check_field("voxel_blue", want.blue, res.voxel_blue);
					check_field("voxel_alpha", want.alpha, res.voxel_alpha);
					check_field("shown_total", want.total, res.shown_total);
				end
			end
			stall_tick <= stall_tick + 1'b1;
			if (hold_left != 0) begin
				res.ready <= 1'b0;
			end else begin
				case (stall_tick[9:8])
					2'd0: res.ready <= 1'b1;
					2'd1: res.ready <= 1'($urandom_range(0, 1));
					2'd2: res.ready <= (stall_tick[2:0] == 3'd0);
					default: res.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[voxel_grid_box_sphere_fill] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DRAW_RED;
		cfg_data <= 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// mark store clear after reset
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);

		// reset colour; first fill writes every voxel
		queue_cmd(mk(CMD_PUT_BOX, 0, 31, 0, 31, 0, 31, 0));
		queue_cmd(mk(CMD_READ_VOXEL, 31, 0, 31, 0, 31, 0, 31));
		queue_cmd(mk(CMD_UNUSED, 0, 31, 31, 31, 0, 31, 31));
		queue_cmd(mk(CMD_CUT_VOXEL, 31, 31, 0, 31, 31, 31, 31));
		queue_cmd(mk(CMD_CUT_VOXEL, 31, 0, 0, 0, 31, 0, 0));
		queue_cmd(mk(CMD_CUT_BOX, 10, 9, 0, 31, 0, 31, 5));
		queue_cmd(mk(CMD_CUT_BOX, 0, 31, 4, 31, 20, 19, 0));
		queue_cmd(mk(CMD_CUT_BOX, 30, 31, 30, 31, 30, 31, 0));
		queue_cmd(mk(CMD_CUT_SPHERE, 0, 0, 0, 0, 0, 0, 3));
		queue_cmd(mk(CMD_CUT_SPHERE, 31, 0, 31, 0, 31, 0, 4));
		queue_cmd(mk(CMD_CUT_SPHERE, 16, 0, 16, 0, 16, 0, 0));
		queue_cmd(mk(CMD_READ_VOXEL, 16, 31, 16, 31, 16, 31, 0));
		wait_idle();

		set_draw(8'd255, 8'd0, 8'd255, 8'd0);
		queue_cmd(mk(CMD_PUT_VOXEL, 31, 0, 0, 0, 31, 0, 0));
		queue_cmd(mk(CMD_PUT_SPHERE, 5, 5, 5, 5, 5, 5, 1));
		queue_cmd(mk(CMD_PUT_SPHERE, 31, 0, 0, 0, 16, 0, 3));
		queue_cmd(mk(CMD_CUT_BOX, 0, 31, 0, 31, 0, 31, 31));
		queue_cmd(mk(CMD_PUT_SPHERE, 16, 0, 16, 0, 16, 0, 31));
		queue_cmd(mk(CMD_CUT_SPHERE, 0, 31, 0, 31, 0, 31, 31));
		queue_cmd(mk(CMD_PUT_SPHERE, 20, 0, 20, 0, 20, 0, 2));
		queue_cmd(mk(CMD_PUT_BOX, 7, 7, 8, 8, 9, 9, 0));
		queue_cmd(mk(CMD_PUT_BOX, 3, 9, 12, 11, 3, 9, 0));
		queue_cmd(mk(CMD_PUT_VOXEL, 0, 31, 0, 31, 0, 31, 31));
		queue_cmd(mk(CMD_READ_VOXEL, 5, 5, 5, 5, 5, 5, 5));

		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: set_draw(8'd0, 8'd0, 8'd0, 8'd0);
				1: set_draw(8'd255, 8'd255, 8'd255, 8'd255);
				default: set_draw(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			repeat (PHASE_ITEMS) queue_cmd(random_cmd());
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0t: %0d result beats never arrived", $time, expected_reports.size());
			failures++;
		end
		if (failures == 0)
			$display("[voxel_grid_box_sphere_fill] OK");
		else
			$display("[voxel_grid_box_sphere_fill] ERROR");
		$finish;
	end

endmodule
